// ===== hdl/fts_pkg.sv =====
package fts_pkg;

  localparam int TRACK_BYTES   = 6250;
  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_RECORDS   = 31;

  localparam int TRK_AW = $clog2(TRACK_BYTES);
  localparam int TAB_AW = $clog2(TABLE_ENTRIES);
  localparam int RI_MIN = $clog2(MAX_RECORDS + 1);
  localparam int RI_W   = (RI_MIN > TAB_AW + 1) ? RI_MIN : TAB_AW + 1;

  localparam int FUNC_W = 2;
  localparam int ADDR_W = 13;
  localparam int DATA_W = 16;
  localparam int POS_W  = 14;
  localparam int CFG_W  = 13;
  localparam int ENT_W  = 16;

  localparam logic [7:0]  FILL_BYTE = 8'hEB;
  localparam logic [7:0]  SYNC_BYTE = 8'hA1;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [12:0] TSIZE_RST = 13'd6400;
  localparam int          MARK_WIN  = 43;

  typedef enum logic [1:0] {
    FN_BEGIN = 2'd0,
    FN_BYTE  = 2'd1,
    FN_POS   = 2'd2,
    FN_EXTR  = 2'd3
  } func_e;

  typedef enum logic {
    CFG_FM    = 1'b0,
    CFG_TSIZE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [POS_W-1:0] id_pos;
    logic             id_crc_bad;
    logic [POS_W-1:0] data_pos;
    logic             data_crc_bad;
    logic             deleted_mark;
    logic [7:0]       cylinder;
    logic [7:0]       head;
    logic [7:0]       sector_id;
    logic [7:0]       size_code;
    logic [4:0]       sector_count;
    logic             too_many;
    logic             last;
  } rec_t;

  typedef struct packed {
    logic              we;
    logic [TRK_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [TRK_AW-1:0] raddr;
  } trk_req_t;

  typedef struct packed {
    logic              we;
    logic [TAB_AW-1:0] waddr;
    logic [ENT_W-1:0]  wdata;
    logic [TAB_AW-1:0] raddr;
  } tab_req_t;

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [7:0] n;
    n = c[15:8] ^ b;
    n = n ^ {4'h0, n[7:4]};
    return {c[7:0], 8'h00} ^ {n[3:0], 12'h000} ^ {3'b000, n, 5'b00000} ^ {8'h00, n};
  endfunction

endpackage

// ===== hdl/fts_in_if.sv =====
interface fts_in_if import fts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;
  modport source(output valid, func, addr, data, input ready);
  modport sink(input valid, func, addr, data, output ready);
endinterface

// ===== hdl/fts_out_if.sv =====
interface fts_out_if import fts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] id_pos;
  logic             id_crc_bad;
  logic [POS_W-1:0] data_pos;
  logic             data_crc_bad;
  logic             deleted_mark;
  logic [7:0]       cylinder;
  logic [7:0]       head;
  logic [7:0]       sector_id;
  logic [7:0]       size_code;
  logic [4:0]       sector_count;
  logic             too_many;
  logic             last;
  modport source(output valid, id_pos, id_crc_bad, data_pos, data_crc_bad, deleted_mark,
                 cylinder, head, sector_id, size_code, sector_count, too_many, last,
                 input ready);
  modport sink(input valid, id_pos, id_crc_bad, data_pos, data_crc_bad, deleted_mark,
               cylinder, head, sector_id, size_code, sector_count, too_many, last,
               output ready);
endinterface

// ===== hdl/floppy_track_sector_scanner_unit.sv =====
// Floppy track sector scanner. Track bytes and ID mark positions are loaded one
// word at a time; an extract word walks the position table and returns one
// sector record per valid entry (at most 31) and then a summary word with last
// set. A single density byte is stored twice. After reset and after every
// begin-track word the block runs a clearing pass over all 6250 bytes of the
// track memory, refilling it with 0xEB and zeroing the position table, and takes
// no word in that time; configuration writes are taken as ever. Extract time is
// set by the single read port of the track memory: each track byte costs a
// request state and a data state. A wrapped position is folded onto the track by
// subtracting 6250, at most twice, and an entry that has no sync bytes is dropped
// by shifting the later table entries down one place. Results wait in an output
// register; the walk stalls while it is full and out_o.ready is low.
module floppy_track_sector_scanner_unit import fts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  fts_in_if.sink           in_i,
  fts_out_if.source        out_o
);

  // configuration registers
  logic             fm_q;
  logic [CFG_W-1:0] tsize_q;

  trk_req_t         trk;
  tab_req_t         tab;
  logic [7:0]       trk_rdata;
  logic [ENT_W-1:0] tab_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fm_q    <= 1'b0;
      tsize_q <= TSIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FM:    fm_q    <= cfg_data_i[0];
        CFG_TSIZE: tsize_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // raw track image
  fts_ram #(.DEPTH(TRACK_BYTES), .WIDTH(8)) u_track (
    .clk_i   (clk_i),
    .we_i    (trk.we),
    .waddr_i (trk.waddr),
    .wdata_i (trk.wdata),
    .raddr_i (trk.raddr),
    .rdata_o (trk_rdata)
  );

  // ID mark position table, bit 15 flags double density
  fts_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(ENT_W)) u_table (
    .clk_i   (clk_i),
    .we_i    (tab.we),
    .waddr_i (tab.waddr),
    .wdata_i (tab.wdata),
    .raddr_i (tab.raddr),
    .rdata_o (tab_rdata)
  );

  // sequencer: loads, clearing pass, table walk and crc checks
  fts_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fm_disk_i    (fm_q),
    .track_size_i (tsize_q),
    .in_i         (in_i),
    .out_o        (out_o),
    .trk_o        (trk),
    .trk_rdata_i  (trk_rdata),
    .tab_o        (tab),
    .tab_rdata_i  (tab_rdata)
  );

endmodule

// ===== hdl/fts_ram.sv =====
module fts_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/fts_walker.sv =====
module fts_walker import fts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fm_disk_i,
  input  logic [CFG_W-1:0] track_size_i,
  fts_in_if.sink           in_i,
  fts_out_if.source        out_o,
  output trk_req_t         trk_o,
  input  logic [7:0]       trk_rdata_i,
  output tab_req_t         tab_o,
  input  logic [ENT_W-1:0] tab_rdata_i
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FMW2, S_TREQ, S_TDAT, S_MOD, S_BREQ, S_BDAT,
    S_CHK, S_SHREQ, S_SHDAT, S_EMIT, S_SREQ, S_SDAT, S_SEMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_ID, PH_SYNC, PH_MARK, PH_DATA
  } phase_e;

  localparam logic [TRK_AW:0] TB    = (TRK_AW+1)'(TRACK_BYTES);
  localparam logic [POS_W-1:0] TBP  = POS_W'(TRACK_BYTES);
  localparam int               HALF = TRACK_BYTES / 2;

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [TRK_AW-1:0]  cnt_q, cnt_d;
  logic [TRK_AW-1:0]  scan_q, scan_d;
  logic [TRK_AW-1:0]  start_q, start_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   mod_q, mod_d;
  logic               dense_q, dense_d;
  logic [15:0]        crc_q, crc_d;
  logic [15:0]        rec_q, rec_d;
  logic [7:0]         mark_q, mark_d;
  logic [7:0]         cyl_q, cyl_d, hd_q, hd_d, sec_q, sec_d, sz_q, sz_d;
  logic               sync_q, sync_d;
  logic               idbad_q, idbad_d, dbad_q, dbad_d, del_q, del_d, tm_q, tm_d;
  logic [POS_W-1:0]   dpos_q, dpos_d;
  logic [RI_W-1:0]    ri_q, ri_d, j_q, j_d;
  logic [TRK_AW-1:0]  waddr_q, waddr_d;
  logic [7:0]         wdat_q, wdat_d;
  logic               ov_q, ov_d;
  rec_t               o_q, o_d;

  logic               free;
  logic [7:0]         b;
  logic [15:0]        c1, c2;
  logic [POS_W-1:0]   p, pr;
  logic [TRK_AW-1:0]  size;

  function automatic logic [TRK_AW-1:0] adv(logic [TRK_AW-1:0] s, logic [3:0] st);
    logic [TRK_AW:0] t;
    t = {1'b0, s} + (TRK_AW+1)'(st);
    if (t >= TB) begin
      t = t - TB;
    end
    return t[TRK_AW-1:0];
  endfunction

  assign free = !ov_q || out_o.ready;
  assign b    = trk_rdata_i;
  assign size = TRK_AW'(128) << sz_q[1:0];

  always_comb begin
    state_d = state_q;  phase_d = phase_q;  cnt_d = cnt_q;  scan_d = scan_q;
    start_d = start_q;  pos_d = pos_q;  mod_d = mod_q;  dense_d = dense_q;
    crc_d = crc_q;  rec_d = rec_q;  mark_d = mark_q;  cyl_d = cyl_q;  hd_d = hd_q;
    sec_d = sec_q;  sz_d = sz_q;  sync_d = sync_q;  idbad_d = idbad_q;
    dbad_d = dbad_q;  del_d = del_q;  tm_d = tm_q;  dpos_d = dpos_q;  ri_d = ri_q;
    j_d = j_q;  waddr_d = waddr_q;  wdat_d = wdat_q;  o_d = o_q;
    ov_d = ov_q && !out_o.ready;
    trk_o = '0;
    tab_o = '0;
    in_i.ready = 1'b0;
    c1 = '0;
    c2 = '0;
    p  = in_i.data[POS_W-1:0];
    pr = '0;

    unique case (state_q)
      S_CLEAR: begin
        trk_o.we    = 1'b1;
        trk_o.waddr = cnt_q;
        trk_o.wdata = FILL_BYTE;
        if (int'(cnt_q) < TABLE_ENTRIES) begin
          tab_o.we    = 1'b1;
          tab_o.waddr = cnt_q[TAB_AW-1:0];
        end
        cnt_d = cnt_q + 1'b1;
        if (int'(cnt_q) == TRACK_BYTES - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          unique case (func_e'(in_i.func))
            FN_BEGIN: begin
              cnt_d   = '0;
              state_d = S_CLEAR;
            end
            FN_BYTE: begin
              if (fm_disk_i) begin
                if (int'(in_i.addr) < HALF) begin
                  trk_o.we    = 1'b1;
                  trk_o.waddr = TRK_AW'({in_i.addr, 1'b0});
                  trk_o.wdata = in_i.data[7:0];
                  waddr_d     = TRK_AW'({in_i.addr, 1'b1});
                  wdat_d      = in_i.data[7:0];
                  state_d     = S_FMW2;
                end
              end else if (int'(in_i.addr) < TRACK_BYTES) begin
                trk_o.we    = 1'b1;
                trk_o.waddr = TRK_AW'(in_i.addr);
                trk_o.wdata = in_i.data[7:0];
              end
            end
            FN_POS: begin
              if (int'(in_i.addr) < TABLE_ENTRIES) begin
                if (p >= POS_W'(128) && p < {1'b0, track_size_i}) begin
                  pr = p - POS_W'(128);
                end
                if (fm_disk_i) begin
                  pr = {pr[POS_W-2:0], 1'b0};
                end
                tab_o.we    = 1'b1;
                tab_o.waddr = TAB_AW'(in_i.addr);
                tab_o.wdata = {in_i.data[15], 1'b0, pr};
              end
            end
            FN_EXTR: begin
              ri_d    = '0;
              state_d = S_TREQ;
            end
            default: ;
          endcase
        end
      end
      S_FMW2: begin
        trk_o.we    = 1'b1;
        trk_o.waddr = waddr_q;
        trk_o.wdata = wdat_q;
        state_d     = S_IDLE;
      end
      S_TREQ: begin
        if (int'(ri_q) >= TABLE_ENTRIES) begin
          state_d = S_SREQ;
        end else begin
          tab_o.raddr = ri_q[TAB_AW-1:0];
          state_d     = S_TDAT;
        end
      end
      S_TDAT: begin
        if (tab_rdata_i[POS_W-1:0] == '0) begin
          state_d = S_SREQ;
        end else begin
          pos_d   = tab_rdata_i[POS_W-1:0];
          mod_d   = tab_rdata_i[POS_W-1:0];
          dense_d = tab_rdata_i[15];
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        // one subtract per cycle until the position lies on the track
        if (mod_q >= TBP) begin
          mod_d = mod_q - TBP;
        end else begin
          start_d = mod_q[TRK_AW-1:0];
          scan_d  = mod_q[TRK_AW-1:0];
          cnt_d   = '0;
          phase_d = PH_ID;
          state_d = S_BREQ;
        end
      end
      S_BREQ: begin
        if (phase_q == PH_SYNC) begin
          trk_o.raddr = scan_q - 1'b1;
        end else begin
          trk_o.raddr = scan_q;
          scan_d      = adv(scan_q, dense_q ? 4'd1 : 4'd2);
        end
        state_d = S_BDAT;
      end
      S_BDAT: begin
        state_d = S_BREQ;
        cnt_d   = cnt_q + 1'b1;
        unique case (phase_q)
          PH_ID: begin
            case (cnt_q[2:0])
              3'd0: mark_d = b;
              3'd1: cyl_d = b;
              3'd2: hd_d = b;
              3'd3: sec_d = b;
              3'd4: sz_d = b;
              3'd5: rec_d[15:8] = b;
              default: rec_d[7:0] = b;
            endcase
            if (cnt_q == TRK_AW'(6)) begin
              crc_d  = CRC_INIT;
              sync_d = 1'b0;
              scan_d = start_q;
              if (!dense_q) begin
                state_d = S_CHK;
              end else if (start_q == '0) begin
                j_d     = ri_q;
                state_d = S_SHREQ;
              end else begin
                phase_d = PH_SYNC;
              end
            end
          end
          PH_SYNC: begin
            if (b == SYNC_BYTE) begin
              crc_d  = crc_byte(crc_q, b);
              sync_d = 1'b1;
              scan_d = scan_q - 1'b1;
              if (scan_q == TRK_AW'(1)) begin
                state_d = S_CHK;
              end
            end else if (sync_q) begin
              state_d = S_CHK;
            end else begin
              j_d     = ri_q;
              state_d = S_SHREQ;
            end
          end
          PH_MARK: begin
            c1 = crc_byte(crc_q, b);
            if (b[7:2] == 6'b111110 && (!dense_q || sync_q)) begin
              if (!dense_q) begin
                c1 = crc_byte(CRC_INIT, b);
              end
              dpos_d  = POS_W'({1'b0, scan_q} + (TRK_AW+1)'(256));
              del_d   = !b[1];
              cnt_d   = '0;
              phase_d = PH_DATA;
            end else begin
              if (b == SYNC_BYTE && dense_q) begin
                if (!sync_q) begin
                  c1 = crc_byte(CRC_INIT, b);
                end
                sync_d = 1'b1;
              end else begin
                sync_d = 1'b0;
              end
              if (int'(cnt_q) == MARK_WIN - 1) begin
                state_d = S_EMIT;
              end
            end
            crc_d = c1;
          end
          default: begin
            if (cnt_q < size) begin
              crc_d = crc_byte(crc_q, b);
            end else if (cnt_q == size) begin
              rec_d[15:8] = b;
            end else begin
              dbad_d  = (crc_q != {rec_q[15:8], b});
              state_d = S_EMIT;
            end
          end
        endcase
      end
      S_CHK: begin
        c1 = crc_byte(crc_q, mark_q);
        c2 = crc_byte(crc_byte(crc_byte(crc_byte(c1, cyl_q), hd_q), sec_q), sz_q);
        crc_d   = c1;
        idbad_d = (c2 != rec_q);
        scan_d  = adv(start_q, dense_q ? 4'd7 : 4'd14);
        cnt_d   = '0;
        sync_d  = 1'b0;
        dpos_d  = '0;
        del_d   = 1'b0;
        dbad_d  = 1'b0;
        phase_d = PH_MARK;
        state_d = S_BREQ;
      end
      S_SHREQ: begin
        // entry without sync: close the gap in the table
        if (int'(j_q) == TABLE_ENTRIES - 1) begin
          tab_o.we    = 1'b1;
          tab_o.waddr = j_q[TAB_AW-1:0];
          state_d     = S_TREQ;
        end else begin
          tab_o.raddr = TAB_AW'(j_q + 1'b1);
          state_d     = S_SHDAT;
        end
      end
      S_SHDAT: begin
        tab_o.we    = 1'b1;
        tab_o.waddr = j_q[TAB_AW-1:0];
        tab_o.wdata = tab_rdata_i;
        j_d         = j_q + 1'b1;
        state_d     = S_SHREQ;
      end
      S_EMIT: begin
        if (free) begin
          ov_d           = 1'b1;
          o_d            = '0;
          o_d.id_pos     = pos_q + POS_W'(257);
          o_d.id_crc_bad = idbad_q;
          o_d.data_pos   = dpos_q;
          o_d.data_crc_bad = dbad_q;
          o_d.deleted_mark = del_q;
          o_d.cylinder   = cyl_q;
          o_d.head       = hd_q;
          o_d.sector_id  = sec_q;
          o_d.size_code  = sz_q;
          ri_d           = ri_q + 1'b1;
          state_d        = (int'(ri_q) + 1 == MAX_RECORDS) ? S_SREQ : S_TREQ;
        end
      end
      S_SREQ: begin
        tab_o.raddr = ri_q[TAB_AW-1:0];
        state_d     = S_SDAT;
      end
      S_SDAT: begin
        tm_d    = (int'(ri_q) == MAX_RECORDS) && (int'(ri_q) < TABLE_ENTRIES) &&
                  (tab_rdata_i[POS_W-1:0] != '0);
        state_d = S_SEMIT;
      end
      S_SEMIT: begin
        if (free) begin
          ov_d             = 1'b1;
          o_d              = '0;
          o_d.sector_count = 5'(ri_q);
          o_d.too_many     = tm_q;
          o_d.last         = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      phase_q <= PH_ID;
      cnt_q   <= '0;
      ri_q    <= '0;
      j_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ri_q    <= ri_d;
      j_q     <= j_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;   start_q <= start_d;  pos_q   <= pos_d;   mod_q  <= mod_d;
    dense_q <= dense_d;  crc_q   <= crc_d;    rec_q   <= rec_d;   mark_q <= mark_d;
    cyl_q   <= cyl_d;    hd_q    <= hd_d;     sec_q   <= sec_d;   sz_q   <= sz_d;
    sync_q  <= sync_d;   idbad_q <= idbad_d;  dbad_q  <= dbad_d;  del_q  <= del_d;
    tm_q    <= tm_d;     dpos_q  <= dpos_d;   waddr_q <= waddr_d; wdat_q <= wdat_d;
    o_q     <= o_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.id_pos       = o_q.id_pos;
  assign out_o.id_crc_bad   = o_q.id_crc_bad;
  assign out_o.data_pos     = o_q.data_pos;
  assign out_o.data_crc_bad = o_q.data_crc_bad;
  assign out_o.deleted_mark = o_q.deleted_mark;
  assign out_o.cylinder     = o_q.cylinder;
  assign out_o.head         = o_q.head;
  assign out_o.sector_id    = o_q.sector_id;
  assign out_o.size_code    = o_q.size_code;
  assign out_o.sector_count = o_q.sector_count;
  assign out_o.too_many     = o_q.too_many;
  assign out_o.last         = o_q.last;

endmodule
